/* design/sha256_pkg.sv */
// Shared types, constants and SHA-256 logic functions for the stream hasher.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package sha256_pkg;

  // Eight 32-bit words; index 0 is word a / H0.
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic init;   // reload the chaining value with the initial hash
    logic load;   // copy the chaining value into the working variables
    logic step;   // run one compression round
    logic fin;    // add the working variables into the chaining value
  } round_ctl_t;

  typedef struct packed {
    logic push_byte;  // shift one message byte in
    logic push_word;  // advance the message schedule by one word
  } sched_ctl_t;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_POS   = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* design/sha256_stream_hasher_top.sv */
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer,
// round control and digest output register. Depends on sha256_pkg,
// sha256_sched and sha256_round.
`timescale 1ns / 1ps

// Channel   | Direction | Ports                          | Contents
// ----------+-----------+--------------------------------+------------------------------
// input     | slave     | in_tvalid/tready/tdata/tuser/  | one message byte, its present
//           |           | tlast                          | flag, end of message
// result    | master    | out_tvalid/tready/tdata        | 256-bit digest, four 64-bit
//           |           |                                | fields
//
// Message bytes enter one per cycle while in_tready is high; every 64th byte
// starts a compression: the load of the working variables together with that
// byte, then the 64 rounds, then the fold of the result into the chaining
// value. No bytes are taken while the single shared round unit is busy.
// After the last transaction the padding bytes are shifted in one per cycle
// up to the end of the block (one or two blocks), each block is compressed,
// and the digest then moves into the output register.
// Reset is synchronous and active low, and the block is then ready with the
// initial hash value in place. in_tready is high only while bytes are
// collected. A digest that is not taken holds in the output register; the
// next message can be collected meanwhile, and only its own digest waits
// until the register is free.

module sha256_stream_hasher_top import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tuser,    // [0] byte_valid
  input  logic         in_tlast,    // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata    // [63:0] digest_0, [127:64] digest_1,
                                    // [191:128] digest_2, [255:192] digest_3
);

  typedef enum logic [4:0] {
    S_IN   = 5'b00001,
    S_COMP = 5'b00010,
    S_FIN  = 5'b00100,
    S_PAD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t       state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [5:0]   round_r, round_nxt;
  logic         pad_r, pad_nxt;         // message ended, padding in progress
  logic         sent80_r, sent80_nxt;   // the 0x80 marker byte is in
  logic         len_r, len_nxt;         // the length field is going in
  logic         out_valid_r, out_valid_nxt;
  logic [255:0] out_data_r;
  logic         out_load;

  logic         in_acc;
  logic         len_sel;
  logic [7:0]   pad_byte;
  logic [7:0]   push_data;
  logic [31:0]  sched_w;
  hash_t        hash;
  round_ctl_t   round_ctl;
  sched_ctl_t   sched_ctl;

  assign in_tready = (state_r == S_IN);
  assign in_acc    = in_tvalid && in_tready;

  // Padding byte: the marker first, zeros up to offset 56 (through an extra
  // block when the marker lands past 55), then the bit count, high byte first.
  assign len_sel  = len_r || (fill_r == LEN_POS);
  assign pad_byte = !sent80_r ? PAD_BYTE :
                    (len_sel ? bits_r[{~fill_r[2:0], 3'b000} +: 8] : 8'h00);

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    round_nxt  = round_r;
    pad_nxt    = pad_r;
    sent80_nxt = sent80_r;
    len_nxt    = len_r;
    out_load   = 1'b0;
    push_data  = in_tdata;
    round_ctl  = '0;
    sched_ctl  = '0;
    unique case (state_r)
      S_IN: begin
        if (in_acc) begin
          if (in_tuser) begin
            sched_ctl.push_byte = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
            if (fill_r == LAST_POS) begin
              round_ctl.load = 1'b1;
              state_nxt = S_COMP;
              pad_nxt = in_tlast;
            end else if (in_tlast) begin
              state_nxt = S_PAD;
              pad_nxt = 1'b1;
            end
          end else if (in_tlast) begin
            state_nxt = S_PAD;
            pad_nxt = 1'b1;
          end
        end
      end
      S_COMP: begin
        round_ctl.step = 1'b1;
        sched_ctl.push_word = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        round_ctl.fin = 1'b1;
        if (len_r) begin
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IN;
        end
      end
      S_PAD: begin
        sched_ctl.push_byte = 1'b1;
        push_data = pad_byte;
        fill_nxt = fill_r + 6'd1;
        if (!sent80_r) begin
          sent80_nxt = 1'b1;
        end else if (len_sel) begin
          len_nxt = 1'b1;
        end
        if (fill_r == LAST_POS) begin
          round_ctl.load = 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          round_ctl.init = 1'b1;
          bits_nxt = '0;
          pad_nxt = 1'b0;
          sent80_nxt = 1'b0;
          len_nxt = 1'b0;
          state_nxt = S_IN;
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      fill_r      <= '0;
      bits_r      <= '0;
      round_r     <= '0;
      pad_r       <= 1'b0;
      sent80_r    <= 1'b0;
      len_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      round_r     <= round_nxt;
      pad_r       <= pad_nxt;
      sent80_r    <= sent80_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Digest register; digest_0 (H0, H1) sits in the lowest bits.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {hash[6], hash[7], hash[4], hash[5],
                     hash[2], hash[3], hash[0], hash[1]};
    end
  end

  sha256_sched u_sched (
    .clk    (clk),
    .ctl_i  (sched_ctl),
    .byte_i (push_data),
    .w_o    (sched_w)
  );

  sha256_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (round_ctl),
    .w_i    (sched_w),
    .k_i    (ROUND_K[round_r]),
    .hash_o (hash)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The last round is always followed by the fold into the chaining value.
  a_last_round_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && round_r == LAST_ROUND) |=> (state_r == S_FIN))
    else $error("last round not followed by the fold cycle");

  // The round counter is back at zero once a compression ends.
  a_round_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (round_r == 6'd0))
    else $error("round counter not at zero after a compression");

  // The length field only goes in after the marker byte of a padded message.
  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    len_r |-> (pad_r && sent80_r))
    else $error("length field started before the marker byte");

  // The digest is only taken on a block boundary.
  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (fill_r == 6'd0))
    else $error("digest taken with a partial block");

  // The 64th byte of a block starts its compression.
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser && fill_r == LAST_POS) |=> (state_r == S_COMP))
    else $error("full block did not start a compression");

endmodule

/* design/sha256_sched.sv */
// Message buffer and rolling 16-word message schedule of the SHA-256 hasher.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_sched import sha256_pkg::*; (
  input  logic        clk,
  input  sched_ctl_t  ctl_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] w_o
);

  // Bytes enter at the bottom; after 64 pushes the first byte sits on top,
  // so the top word is schedule word 0 in big-endian order.
  logic [511:0] msg_r, msg_nxt;
  logic [31:0]  w0, w1, w9, w14, w_new;

  assign w0  = msg_r[511:480];
  assign w1  = msg_r[479:448];
  assign w9  = msg_r[223:192];
  assign w14 = msg_r[63:32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  always_comb begin
    msg_nxt = msg_r;
    if (ctl_i.push_word) begin
      msg_nxt = {msg_r[479:0], w_new};
    end else if (ctl_i.push_byte) begin
      msg_nxt = {msg_r[503:0], byte_i};
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

  assign w_o = w0;

endmodule

/* design/sha256_round.sv */
// Shared SHA-256 round unit: working variables and chaining value.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  round_ctl_t  ctl_i,
  input  logic [31:0] w_i,
  input  logic [31:0] k_i,
  output hash_t       hash_o
);

  hash_t       hash_r, hash_nxt;
  hash_t       vars_r, vars_nxt;
  logic [31:0] t1, t2, ch, maj;

  assign ch  = (vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]);
  assign maj = (vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]);
  assign t1  = vars_r[7] + big_sigma1(vars_r[4]) + ch + k_i + w_i;
  assign t2  = big_sigma0(vars_r[0]) + maj;

  always_comb begin
    vars_nxt = vars_r;
    hash_nxt = hash_r;
    if (ctl_i.load) begin
      vars_nxt = hash_r;
    end else if (ctl_i.step) begin
      vars_nxt[0] = t1 + t2;
      vars_nxt[1] = vars_r[0];
      vars_nxt[2] = vars_r[1];
      vars_nxt[3] = vars_r[2];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[5] = vars_r[4];
      vars_nxt[6] = vars_r[5];
      vars_nxt[7] = vars_r[6];
    end
    if (ctl_i.init) begin
      hash_nxt = INIT_HASH;
    end else if (ctl_i.fin) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + vars_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= INIT_HASH;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

  assign hash_o = hash_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the SHA-256 stream hasher: message bytes go in as
// stream transactions and every digest is checked against a predictor in this file.
// Depends on sha256_stream_hasher_top and, through it, on sha256_pkg.
`timescale 1ns / 1ps

module tb;

  // A digest as four 64-bit fields. Field 0 sits in the low bits, the same
  // way out_tdata carries it.
  typedef logic [3:0][63:0] digest_t;

  // One input transaction: a message byte, its present flag and the end mark.
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       is_last;
  } byte_item_t;

  localparam int WATCHDOG_LIMIT = 5000;
  // Idle wait at the end of the run, sized to cover two compressions, the
  // padding shift and the output register after the final transaction.
  localparam int DRAIN_CYCLES   = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;

  sha256_stream_hasher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The SHA-256 round constants, kept here so the predictor stands on its own.
  logic [31:0] k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Predictor state: chaining value, the block being filled, its fill level
  // and the running message length in bits.
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  byte_item_t pending [$];      // stimulus not yet offered to the block
  digest_t    digests_due [$];  // digests predicted but not yet received

  int err_count     = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 61;
  int quiet_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds over the current block and folds the result into the
  // chaining value. The schedule is expanded in full up front.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic restart_message();
    chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    blk_fill = '0;
    msg_bits = '0;
  endtask

  // Advances the predictor by one accepted transaction. A message ends with
  // the pad byte, zero fill and the bit length; when the length no longer
  // fits behind the pad, one more block is compressed first.
  task automatic absorb_item(logic [7:0] data, logic present, logic is_last);
    digest_t d;
    if (present) begin
      blk[blk_fill] = data;
      msg_bits = msg_bits + 64'd8;
      blk_fill = blk_fill + 6'd1;
      if (blk_fill == 6'd0) compress_block();
    end
    if (is_last) begin
      blk[blk_fill] = 8'h80;
      for (int i = int'(blk_fill) + 1; i < 64; i++) blk[i] = 8'h00;
      if (blk_fill >= 6'd56) begin
        compress_block();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 4; i++) d[i] = {chain[2*i], chain[2*i+1]};
      digests_due.push_back(d);
      restart_message();
    end
  endtask

  // Message bytes lean toward the all-zeros and all-ones patterns now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Most messages are short; a good share sit on the padding boundaries where
  // the length field spills into an extra block, and a few span several blocks.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(16);
    if (sel < 80) begin
      case ($urandom_range(9))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        7: return 120;
        8: return 127;
        default: return 128;
      endcase
    end
    if (sel < 96) return $urandom_range(130, 17);
    return $urandom_range(260, 131);
  endfunction

  // Queues one message. It either ends on its last byte or on a separate
  // transaction that carries no byte; a few ignored transactions (no byte,
  // not last) are scattered through it.
  task automatic add_message(int n_bytes, bit empty_end);
    byte_item_t it;
    for (int k = 0; k < n_bytes; k++) begin
      if ($urandom_range(99) < 4) begin
        pending.push_back('{data: pick_byte(), present: 1'b0, is_last: 1'b0});
      end
      it.data    = pick_byte();
      it.present = 1'b1;
      it.is_last = !empty_end && (k == n_bytes - 1);
      pending.push_back(it);
    end
    if (empty_end || n_bytes == 0) begin
      pending.push_back('{data: pick_byte(), present: 1'b0, is_last: 1'b1});
    end
  endtask

  task automatic add_random_messages(int quota);
    int added;
    int n_bytes;
    bit empty_end;
    added = 0;
    while (added < quota) begin
      n_bytes   = pick_length();
      empty_end = ($urandom_range(3) == 0) || (n_bytes == 0);
      add_message(n_bytes, empty_end);
      added += n_bytes + (empty_end ? 1 : 0);
    end
  endtask

  // Blocks until every queued transaction has gone in and every digest is out.
  task automatic wait_drained();
    while (pending.size() != 0 || in_tvalid || digests_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver. The predictor advances on the edge where a transaction is
  // accepted, using the values that were on the bus at that edge. A new
  // transaction (or an idle cycle) is chosen only once the current one is gone.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        absorb_item(in_tdata, in_tuser, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending[0].data;
          in_tuser  <= pending[0].present;
          in_tlast  <= pending[0].is_last;
          void'(pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted digest is compared field by field with the oldest
  // prediction; the ready line is redrawn every cycle.
  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (digests_due.size() == 0) begin
          $display("%0t: unexpected digest, expected none, actual %h", $time, got);
          err_count++;
        end else begin
          want = digests_due.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got[f] !== want[f]) begin
              $display("%0t: digest_%0d mismatch, expected %h, actual %h",
                       $time, f, want[f], got[f]);
              err_count++;
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side means
  // the block has hung.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    restart_message();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed messages. The empty message comes first, straight out of reset.
    add_message(0, 1'b1);
    // The classic three-byte message, ending on its last byte.
    pending.push_back('{data: 8'h61, present: 1'b1, is_last: 1'b0});
    pending.push_back('{data: 8'h62, present: 1'b1, is_last: 1'b0});
    pending.push_back('{data: 8'h63, present: 1'b1, is_last: 1'b1});
    // Ignored transactions around the extreme byte values, then a message
    // that ends on a transaction without a byte.
    pending.push_back('{data: 8'ha5, present: 1'b0, is_last: 1'b0});
    pending.push_back('{data: 8'h00, present: 1'b1, is_last: 1'b0});
    pending.push_back('{data: 8'hff, present: 1'b1, is_last: 1'b0});
    pending.push_back('{data: 8'h5a, present: 1'b0, is_last: 1'b0});
    pending.push_back('{data: 8'hff, present: 1'b0, is_last: 1'b1});
    // Single-byte messages at both extremes.
    pending.push_back('{data: 8'hff, present: 1'b1, is_last: 1'b1});
    pending.push_back('{data: 8'h00, present: 1'b1, is_last: 1'b1});
    // An empty message reached after an ignored transaction.
    pending.push_back('{data: 8'h00, present: 1'b0, is_last: 1'b0});
    pending.push_back('{data: 8'h00, present: 1'b0, is_last: 1'b1});

    // Random traffic in three phases: the sender idles more lightly than the
    // receiver, then the reverse, then both run flat out.
    add_random_messages(630);
    wait_drained();
    send_idle_pct = 61;
    recv_idle_pct = 36;
    add_random_messages(630);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_messages(630);
    wait_drained();

    // Leave room for any stray digest to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
